// ===== hdl/wgm_pkg.sv =====
// package: shared constants, types and arithmetic helpers for the waveguide mesh
package wgm_pkg;

  localparam int MESH_SIDE = 7;
  localparam int WAVE_BITS = 24;

  localparam int JCOUNT  = MESH_SIDE * MESH_SIDE;
  localparam int JW      = $clog2(JCOUNT);
  localparam int AW      = JW + 1;
  localparam int CW      = $clog2(MESH_SIDE);
  localparam int CMPW    = (CW > 3) ? CW : 3;
  localparam int SUMW    = WAVE_BITS + 2;
  localparam int PRODW   = SUMW + 16;
  localparam int RPW     = WAVE_BITS + 16;
  localparam int SATW    = 64;
  localparam int PV_BITS = 24;

  localparam int Q_SHIFT    = 15;
  localparam int ROUND_HALF = 16384;
  localparam int EXC_SHIFT  = 5;

  localparam logic [2:0] CFG_STRIKE_X = 3'd0;
  localparam logic [2:0] CFG_STRIKE_Y = 3'd1;
  localparam logic [2:0] CFG_PROBE_X  = 3'd2;
  localparam logic [2:0] CFG_PROBE_Y  = 3'd3;
  localparam logic [2:0] CFG_GAIN     = 3'd4;
  localparam logic [2:0] CFG_EDGE     = 3'd5;

  localparam logic signed [SATW-1:0] WMAX =
    {{(SATW-WAVE_BITS+1){1'b0}}, {(WAVE_BITS-1){1'b1}}};
  localparam logic signed [SATW-1:0] WMIN = ~WMAX;
  localparam logic signed [SATW-1:0] PMAX =
    {{(SATW-PV_BITS+1){1'b0}}, {(PV_BITS-1){1'b1}}};
  localparam logic signed [SATW-1:0] PMIN = ~PMAX;

  typedef logic signed [WAVE_BITS-1:0] wave_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic mul;
    logic vel;
    logic outc;
    logic wa;
    logic wb;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic last_j;
    logic out_free;
  } sts_t;

  function automatic wave_t sat_wave(input logic signed [SATW-1:0] x);
    logic signed [SATW-1:0] y;
    y = x;
    if (x > WMAX) y = WMAX;
    if (x < WMIN) y = WMIN;
    return y[WAVE_BITS-1:0];
  endfunction

  function automatic logic signed [PV_BITS-1:0] sat_pv(input logic signed [SATW-1:0] x);
    logic signed [SATW-1:0] y;
    y = x;
    if (x > PMAX) y = PMAX;
    if (x < PMIN) y = PMIN;
    return y[PV_BITS-1:0];
  endfunction

endpackage

// ===== hdl/wgm_in_if.sv =====
// interface: input sample channel
interface wgm_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] excite_sample;
  logic               last_in_block;
  modport source (output valid, excite_sample, last_in_block, input ready);
  modport sink (input valid, excite_sample, last_in_block, output ready);
endinterface

// ===== hdl/wgm_out_if.sv =====
// interface: result channel
interface wgm_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] probe_velocity;
  logic               last_out_block;
  modport source (output valid, probe_velocity, last_out_block, input ready);
  modport sink (input valid, probe_velocity, last_out_block, output ready);
endinterface

// ===== hdl/wgm_cfg_if.sv =====
// interface: configuration write channel
interface wgm_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/wgm_ram.sv =====
// generic single write, single registered read memory
module wgm_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 24
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ===== hdl/wgm_ctrl.sv =====
// controller: sequences one mesh step over all junctions
module wgm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  wgm_pkg::sts_t sts_i,
  output wgm_pkg::cmd_t cmd_o
);
  import wgm_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_VEL  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;
  localparam logic [2:0] S_WA   = 3'd5;
  localparam logic [2:0] S_WB   = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0] state_q, state_d;
  logic       in_fire;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_RD;
        end
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_VEL;
      end
      S_VEL: begin
        cmd_o.vel = 1'b1;
        state_d   = S_OUT;
      end
      S_OUT: begin
        cmd_o.outc = 1'b1;
        state_d    = S_WA;
      end
      S_WA: begin
        cmd_o.wa = 1'b1;
        state_d  = S_WB;
      end
      S_WB: begin
        cmd_o.wb = 1'b1;
        state_d  = sts_i.last_j ? S_DONE : S_RD;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_accept_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == S_RD) else $error("accept did not start a sweep");
  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> sts_i.out_free) else $error("result overwritten");
  a_finish_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> state_q == S_IDLE) else $error("sweep did not return to idle");
endmodule

// ===== hdl/wgm_datapath.sv =====
// datapath: config registers, wave memories, scattering arithmetic, result register
module wgm_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wgm_pkg::cmd_t      cmd_i,
  output wgm_pkg::sts_t      sts_o,
  input  logic signed [15:0] excite_sample_i,
  input  logic               last_in_block_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [23:0] probe_velocity_o,
  output logic               last_out_block_o
);
  import wgm_pkg::*;

  // configuration
  logic [2:0]         strike_x_q, strike_y_q, probe_x_q, probe_y_q;
  logic [14:0]        gain_q;
  logic signed [15:0] edge_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strike_x_q <= 3'd2;
      strike_y_q <= 3'd4;
      probe_x_q  <= 3'd2;
      probe_y_q  <= 3'd2;
      gain_q     <= 15'd16384;
      edge_q     <= -16'sd32440;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_STRIKE_X: strike_x_q <= cfg_data_i[2:0];
        CFG_STRIKE_Y: strike_y_q <= cfg_data_i[2:0];
        CFG_PROBE_X:  probe_x_q  <= cfg_data_i[2:0];
        CFG_PROBE_Y:  probe_y_q  <= cfg_data_i[2:0];
        CFG_GAIN:     gain_q     <= cfg_data_i[14:0];
        CFG_EDGE:     edge_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sweep position and bank control
  logic [JW-1:0] j_q;
  logic [CW-1:0] r_q, c_q;
  logic          bank_q, primed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_q      <= '0;
      r_q      <= '0;
      c_q      <= '0;
      bank_q   <= 1'b0;
      primed_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        j_q <= '0;
        r_q <= '0;
        c_q <= '0;
      end else if (cmd_i.wb) begin
        j_q <= j_q + JW'(1);
        if (c_q == CW'(MESH_SIDE - 1)) begin
          c_q <= '0;
          r_q <= r_q + CW'(1);
        end else begin
          c_q <= c_q + CW'(1);
        end
      end
      if (cmd_i.finish) begin
        bank_q   <= ~bank_q;
        primed_q <= 1'b1;
      end
    end
  end

  // sample payload
  logic signed [15:0] excite_q;
  logic               last_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      excite_q <= excite_sample_i;
      last_q   <= last_in_block_i;
    end
  end

  // wave memories, one per port, two banks each
  logic          we   [4];
  logic [AW-1:0] wad  [4];
  wave_t         wdat [4];
  wave_t         rdat [4];
  wave_t         in_w [4];

  for (genvar k = 0; k < 4; k++) begin : g_mem
    wgm_ram #(.DEPTH(2 ** AW), .WIDTH(WAVE_BITS)) u_ram (
      .clk_i   (clk_i),
      .we_i    (we[k]),
      .waddr_i (wad[k]),
      .wdata_i (wdat[k]),
      .re_i    (cmd_i.rd),
      .raddr_i ({bank_q, j_q}),
      .rdata_o (rdat[k])
    );
    // a bank that was never written reads as silence
    assign in_w[k] = primed_q ? rdat[k] : '0;
  end

  // velocity
  logic signed [PRODW-1:0] prod_q, prod_d, rnd, vsum;
  logic signed [SUMW-1:0]  sum;
  wave_t                   v_q;
  logic                    hit_strike, hit_probe;
  logic signed [PV_BITS-1:0] pv_q;

  always_comb begin
    sum = SUMW'(in_w[0]) + SUMW'(in_w[1]) + SUMW'(in_w[2]) + SUMW'(in_w[3]);
    prod_d = PRODW'(sum) * PRODW'($signed({1'b0, gain_q}));
    rnd = (prod_q + PRODW'(ROUND_HALF)) >>> Q_SHIFT;
    hit_strike = (CMPW'(r_q) == CMPW'(strike_x_q)) && (CMPW'(c_q) == CMPW'(strike_y_q));
    hit_probe  = (CMPW'(r_q) == CMPW'(probe_x_q)) && (CMPW'(c_q) == CMPW'(probe_y_q));
    vsum = rnd + (hit_strike ? (PRODW'(excite_q) <<< EXC_SHIFT) : '0);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) prod_q <= prod_d;
    if (cmd_i.vel) v_q <= sat_wave(SATW'(vsum));
    if (cmd_i.load) pv_q <= '0;
    else if (cmd_i.vel && hit_probe) pv_q <= sat_pv(SATW'(vsum));
  end

  // outgoing waves
  wave_t o_q [4];
  always_ff @(posedge clk_i) begin
    if (cmd_i.outc) begin
      for (int k = 0; k < 4; k++) begin
        o_q[k] <= sat_wave(SATW'(v_q) - SATW'(in_w[k]));
      end
    end
  end

  // edge reflections, north/east in the first write beat, south/west in the second
  logic signed [RPW-1:0] pa, pb;
  wave_t                 refl_a, refl_b;
  logic                  e_n, e_e, e_s, e_w;
  logic                  nb;

  always_comb begin
    pa = RPW'(cmd_i.wa ? o_q[0] : o_q[2]) * RPW'(edge_q);
    pb = RPW'(cmd_i.wa ? o_q[1] : o_q[3]) * RPW'(edge_q);
    refl_a = sat_wave(SATW'((pa + RPW'(ROUND_HALF)) >>> Q_SHIFT));
    refl_b = sat_wave(SATW'((pb + RPW'(ROUND_HALF)) >>> Q_SHIFT));
    e_n = (r_q == '0);
    e_e = (c_q == CW'(MESH_SIDE - 1));
    e_s = (r_q == CW'(MESH_SIDE - 1));
    e_w = (c_q == '0);
    nb  = ~bank_q;

    // north port store
    we[0]   = (cmd_i.wa && e_n) || (cmd_i.wb && !e_s);
    wad[0]  = {nb, cmd_i.wa ? j_q : j_q + JW'(MESH_SIDE)};
    wdat[0] = cmd_i.wa ? refl_a : o_q[2];
    // east port store
    we[1]   = (cmd_i.wa && e_e) || (cmd_i.wb && !e_w);
    wad[1]  = {nb, cmd_i.wa ? j_q : j_q - JW'(1)};
    wdat[1] = cmd_i.wa ? refl_b : o_q[3];
    // south port store
    we[2]   = (cmd_i.wa && !e_n) || (cmd_i.wb && e_s);
    wad[2]  = {nb, cmd_i.wa ? j_q - JW'(MESH_SIDE) : j_q};
    wdat[2] = cmd_i.wa ? o_q[0] : refl_a;
    // west port store
    we[3]   = (cmd_i.wa && !e_e) || (cmd_i.wb && e_w);
    wad[3]  = {nb, cmd_i.wa ? j_q + JW'(1) : j_q};
    wdat[3] = cmd_i.wa ? o_q[1] : refl_b;
  end

  // result register
  logic               out_valid_q;
  logic signed [23:0] out_pv_q;
  logic               out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_pv_q   <= pv_q;
      out_last_q <= last_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign probe_velocity_o = out_pv_q;
  assign last_out_block_o = out_last_q;

  assign sts_o.last_j   = (j_q == JW'(JCOUNT - 1));
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  a_valid_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.finish)) else $error("result without step");
  a_j_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd |-> j_q <= JW'(JCOUNT - 1)) else $error("junction index out of mesh");
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(out_pv_q) && $stable(out_last_q))
    else $error("waiting result changed");
endmodule

// ===== hdl/waveguide_mesh_2d_step.sv =====
// top level: rectilinear 2-d waveguide mesh, one audio sample per beat
//
// in_i carries one sample tick per beat (excitation and buffer marker);
// res_o returns one beat per tick with the probe junction velocity and the
// copied marker; cfg_i writes the strike, probe, gain and edge registers and
// is always ready. The user must write configuration only while no tick is
// in flight; the block itself does not enforce this. A tick is accepted only
// when the sweep is idle. The sweep then walks all MESH_SIDE*MESH_SIDE
// junctions, each through memory read, gain multiply, velocity, outgoing
// waves and two write beats into the four port memories; junctions are
// walked one at a time with no overlap between their steps. The result
// lands in an output register; the next tick can be accepted while it
// waits. If the receiver stalls longer than a whole sweep, the block
// holds at the end of the sweep until the result register is free.
// Reset restores the register defaults and a silent mesh at once: the
// wave memories are double-banked and the first bank read reads as zero.
module waveguide_mesh_2d_step (
  input  logic clk_i,
  input  logic rst_ni,
  wgm_in_if.sink    in_i,
  wgm_out_if.source res_o,
  wgm_cfg_if.sink   cfg_i
);
  import wgm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // configuration never stalls
  assign cfg_i.ready = 1'b1;

  wgm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wgm_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .excite_sample_i  (in_i.excite_sample),
    .last_in_block_i  (in_i.last_in_block),
    .cfg_we_i         (cfg_i.valid),
    .cfg_index_i      (cfg_i.index),
    .cfg_data_i       (cfg_i.data),
    .out_valid_o      (res_o.valid),
    .out_ready_i      (res_o.ready),
    .probe_velocity_o (res_o.probe_velocity),
    .last_out_block_o (res_o.last_out_block)
  );
endmodule

// ===== tb/tb.sv =====
// testbench for the waveguide mesh: bit-true mesh predictor, scoreboard and beat drivers
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wgm_pkg::*;

  // one expected result beat
  typedef struct {
    logic signed [23:0] velocity;
    logic               last;
  } tick_res_t;

  // mesh predictor plus store of expected probe velocities
  class mesh_scoreboard;
    longint           waves[JCOUNT*4];
    logic [2:0]       strike_row, strike_col, probe_row, probe_col;
    logic [14:0]      gain;
    logic signed [15:0] edge_coef;
    tick_res_t        pending[$];
    int               failures;

    function new();
      foreach (waves[i]) waves[i] = 0;
      strike_row = 3'd2; strike_col = 3'd4;
      probe_row  = 3'd2; probe_col  = 3'd2;
      gain       = 15'd16384;
      edge_coef  = -16'sd32440;
      failures   = 0;
    endfunction

    // clamp to the wave width
    function longint clamp(longint x);
      longint hi;
      hi = (longint'(1) <<< (WAVE_BITS-1)) - 1;
      if (x > hi) return hi;
      if (x < -hi-1) return -hi-1;
      return x;
    endfunction

    // Q1.15 product, round half up
    function longint q15(longint p);
      return (p + ROUND_HALF) >>> Q_SHIFT;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        CFG_STRIKE_X: strike_row = data[2:0];
        CFG_STRIKE_Y: strike_col = data[2:0];
        CFG_PROBE_X:  probe_row  = data[2:0];
        CFG_PROBE_Y:  probe_col  = data[2:0];
        CFG_GAIN:     gain       = data[14:0];
        CFG_EDGE:     edge_coef  = data;
        default: ;
      endcase
    endfunction

    // one audio tick through the whole mesh
    function void note_tick(logic signed [15:0] excite, logic last);
      longint    vel[JCOUNT];
      longint    nxt[JCOUNT*4];
      longint    sum, o;
      int        j, nr, nc;
      tick_res_t res;
      for (int r = 0; r < MESH_SIDE; r++)
        for (int c = 0; c < MESH_SIDE; c++) begin
          j = r*MESH_SIDE + c;
          sum = 0;
          for (int d = 0; d < 4; d++) sum += waves[j*4+d];
          vel[j] = q15(longint'(gain) * sum);
          if (r == strike_row && c == strike_col)
            vel[j] += longint'(excite) * 32;
          vel[j] = clamp(vel[j]);
        end
      for (int r = 0; r < MESH_SIDE; r++)
        for (int c = 0; c < MESH_SIDE; c++) begin
          j = r*MESH_SIDE + c;
          for (int d = 0; d < 4; d++) begin
            o  = clamp(vel[j] - waves[j*4+d]);
            nr = r + ((d == 0) ? -1 : (d == 2) ? 1 : 0);
            nc = c + ((d == 3) ? -1 : (d == 1) ? 1 : 0);
            if (nr < 0 || nr >= MESH_SIDE || nc < 0 || nc >= MESH_SIDE)
              nxt[j*4+d] = clamp(q15(longint'(edge_coef) * o));
            else
              nxt[(nr*MESH_SIDE+nc)*4 + ((d+2)&3)] = o;
          end
        end
      waves = nxt;
      res.velocity = 24'sd0;
      if (probe_row < MESH_SIDE && probe_col < MESH_SIDE)
        res.velocity = 24'(vel[probe_row*MESH_SIDE + probe_col]);
      res.last = last;
      pending.push_back(res);
    endfunction

    function void check_result(logic signed [23:0] velocity, logic last);
      tick_res_t exp_res;
      if (pending.size() == 0) begin
        $error("unexpected result beat: probe_velocity %0d", velocity);
        failures++;
        return;
      end
      exp_res = pending.pop_front();
      if (velocity !== exp_res.velocity) begin
        $error("probe_velocity: expected %0d, got %0d", exp_res.velocity, velocity);
        failures++;
      end
      if (last !== exp_res.last) begin
        $error("last_out_block: expected %0b, got %0b", exp_res.last, last);
        failures++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  wgm_in_if  in_if();
  wgm_out_if res_if();
  wgm_cfg_if cfg_if();

  waveguide_mesh_2d_step dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  mesh_scoreboard sb = new();
  bit quiet;      // no idling in the closing stretch
  bit hold_req;   // asks the receiver for one long hold-off

  // 20 ns clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // reset once, inputs known from time zero
  initial begin
    rst_n = 1'b0;
    in_if.valid <= 1'b0; in_if.excite_sample <= '0; in_if.last_in_block <= 1'b0;
    res_if.ready <= 1'b0;
    cfg_if.valid <= 1'b0; cfg_if.index <= '0; cfg_if.data <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  // overall time limit
  initial begin
    #80ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // receiver: random stall bursts, one long hold so the block backs up
  initial begin
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        res_if.ready <= 1'b0;
        repeat (1500) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      @(posedge clk);
      if (res_if.valid && res_if.ready)
        sb.check_result(res_if.probe_velocity, res_if.last_out_block);
    end
  end

  // one register write beat, mirrored into the predictor
  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    sb.write_reg(idx, data);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait until the mesh has drained, then let it settle
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // full register set; junction coordinates carry random upper bits
  task automatic set_mesh(int sr, int sc, int pr, int pc, int g, int e);
    write_reg(CFG_STRIKE_X, 16'(($urandom & 16'hfff8) | sr));
    write_reg(CFG_STRIKE_Y, 16'(($urandom & 16'hfff8) | sc));
    write_reg(CFG_PROBE_X,  16'(($urandom & 16'hfff8) | pr));
    write_reg(CFG_PROBE_Y,  16'(($urandom & 16'hfff8) | pc));
    write_reg(CFG_GAIN,     16'(($urandom & 16'h8000) | g));
    write_reg(CFG_EDGE,     16'(e));
  endtask

  // one sample beat, with an optional random gap first
  task automatic send_tick(logic signed [15:0] excite, logic last);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.excite_sample <= excite;
    in_if.last_in_block <= last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_tick(excite, last);
  endtask

  // random excitation: mostly silence, with mallet strikes that then ring out
  task automatic run_ticks(int count);
    int burst;
    burst = 0;
    for (int k = 0; k < count; k++) begin
      if (burst == 0 && $urandom_range(0, 19) == 0) burst = $urandom_range(1, 4);
      if (burst > 0) begin
        burst--;
        send_tick(16'($urandom), 1'($urandom_range(0, 1)));
      end else if ($urandom_range(0, 29) == 0)
        send_tick(16'($urandom), 1'($urandom_range(0, 1)));   // stray noise
      else
        send_tick(16'sd0, ($urandom_range(0, 15) == 0));
    end
  endtask

  initial begin
    int sr, sc, pr, pc, g;
    @(posedge rst_n);
    @(posedge clk);

    // directed: reset registers, excitation extremes and marker values
    send_tick(16'sd32767, 1'b0);
    send_tick(-16'sd32768, 1'b1);
    send_tick(16'sd1, 1'b0);
    send_tick(-16'sd1, 1'b1);
    send_tick(16'sd0, 1'b0);
    send_tick(16'sd0, 1'b1);
    drain();

    // unknown register indexes must change nothing
    write_reg(3'd6, 16'($urandom));
    write_reg(3'd7, 16'($urandom));
    send_tick(16'sd0, 1'b0);
    drain();

    // strike off the mesh, probe on a corner, loud gain
    set_mesh(7, 0, 0, 0, 32767, 32767);
    send_tick(16'sd32767, 1'b0);
    send_tick(16'sd0, 1'b1);
    drain();
    // probe off the mesh
    set_mesh(0, 0, 3, 7, 16384, -32768);
    send_tick(-16'sd32768, 1'b0);
    send_tick(16'sd0, 1'b0);
    drain();
    // gain above one half drives the mesh into saturation
    set_mesh(6, 6, 6, 6, 32767, 32767);
    for (int k = 0; k < 8; k++) send_tick(16'sd32767, k[0]);
    drain();
    // zero gain and zero edge: silent apart from the strike
    set_mesh(3, 3, 3, 3, 0, 0);
    send_tick(16'sd32767, 1'b0);
    send_tick(16'sd0, 1'b1);
    drain();

    // random phases, each with its own register set
    for (int ph = 0; ph < 16; ph++) begin
      sr = ($urandom_range(0, 9) == 0) ? 7 : $urandom_range(0, 6);
      sc = ($urandom_range(0, 9) == 0) ? 7 : $urandom_range(0, 6);
      pr = ($urandom_range(0, 9) == 0) ? 7 : $urandom_range(0, 6);
      pc = ($urandom_range(0, 9) == 0) ? 7 : $urandom_range(0, 6);
      case ($urandom_range(0, 3))
        0:       g = $urandom_range(0, 32767);
        1:       g = 16384;
        default: g = $urandom_range(14000, 16384);
      endcase
      set_mesh(sr, sc, pr, pc, g, ($urandom_range(0, 1)) ? $urandom : -32440);
      if (ph == 4) hold_req = 1'b1;   // long receiver hold while we keep sending
      if (ph == 13) quiet = 1'b1;     // closing stretch with no idling
      run_ticks(95);
      drain();
    end

    // drained above; allow for any beat still on its way
    repeat (320) @(posedge clk);
    if (sb.failures == 0 && sb.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/wgm_pkg.sv
hdl/wgm_in_if.sv
hdl/wgm_out_if.sv
hdl/wgm_cfg_if.sv
hdl/wgm_ram.sv
hdl/wgm_ctrl.sv
hdl/wgm_datapath.sv
hdl/waveguide_mesh_2d_step.sv
tb/tb.sv
